### design/bgpg_pkg.sv
// Shared constants, codes and controller/datapath interface types of the glyph pixel generator.
package bgpg_pkg;

    // Store and glyph geometry
    localparam int FONT_BYTES  = 1024;
    localparam int MAX_GLYPH_W = 8;
    localparam int MAX_GLYPH_H = 8;
    localparam int COORD_BITS  = 12;

    // Derived widths
    localparam int FONT_AW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
    localparam int IDX_W   = (FONT_AW + 1 > 12) ? FONT_AW + 1 : 12;
    localparam int WW      = $clog2(MAX_GLYPH_W + 1);
    localparam int HW      = $clog2(MAX_GLYPH_H + 1);
    localparam int CW      = (MAX_GLYPH_W > 1) ? $clog2(MAX_GLYPH_W) : 1;
    localparam int RW      = (MAX_GLYPH_H > 1) ? $clog2(MAX_GLYPH_H) : 1;

    // Port widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_GLYPH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_CODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_CODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_BYTES  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_ON     = 3'd5;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CALC,
        ST_FETCH,
        ST_DRAIN,
        ST_EMIT,
        ST_MARK
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic calc;
        logic fetch;
        logic emit_pixel;
        logic emit_marker;
        logic adv_cursor;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_glyph;
        logic in_range;
        logic no_pixels;
        logic fetch_last;
        logic pix_last;
        logic out_free;
    } stat_t;

endpackage

### design/bitmap_glyph_pixel_generator.sv
// Top level of the bitmap glyph pixel generator.
//
// Input stream (s_axis): tuser selects the item kind. A load item writes one column
// byte of the font store, a start item places the string cursor and clears the width
// sum, a glyph item draws one character. Load and start items give
// no output. Output stream (m_axis): one item per pixel, rows outer and columns inner,
// tuser high for a pixel write and low for a marker; tlast closes each glyph item.
// A glyph whose code is outside the font range gives one marker.
// A drawn glyph of ncols fetched columns and H rows goes through the setup, calc, fetch,
// drain and emit states: the fetch reads its columns through the single read port of the
// font store into the column buffer, and the emit gives one pixel per cycle while the
// receiver does not stall, ncols*H pixels in all.
// One glyph is worked at a time; the next item is taken once its last output item is
// in the output register. A stalled receiver holds the output register and the pixel
// counters in place. Reset clears the cursor, the width sum and the output valid flag, and loads
// the default registers; the font store is not cleared and must be loaded before use.
// The configuration channel is always ready and must be written only while idle.
module bitmap_glyph_pixel_generator
    import bgpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // font_addr, font_byte, start_x, start_y, char_code
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_value, advance, width_sum
    output logic                   m_axis_tuser,   // pixel_valid
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Register writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    // Sequencer
    bgpg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Storage and arithmetic
    bgpg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

### design/bgpg_ctrl.sv
// Controller state machine that sequences setup, column fetch and pixel emission.
module bgpg_ctrl
    import bgpg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_axis_tvalid,
    output logic  s_axis_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.is_glyph)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
                if (!stat.in_range)
                begin
                    state_next = ST_MARK;
                end
                else if (stat.no_pixels)
                begin
                    // In-range glyph with nothing to draw still moves the cursor.
                    cmd.adv_cursor = 1'b1;
                    state_next     = ST_MARK;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (stat.fetch_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pixel = 1'b1;
                    if (stat.pix_last)
                    begin
                        cmd.adv_cursor = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_marker = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/bgpg_datapath.sv
// Datapath: configuration registers, font store, cursor state, column buffer and output register.
module bgpg_datapath
    import bgpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // font_addr, font_byte, start_x, start_y, char_code
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_value, advance, width_sum
    output logic                   m_axis_tuser,   // pixel_valid
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cmd_t                   cmd,
    output stat_t                  stat
);

    // Input fields
    logic [9:0]  font_addr;
    logic [7:0]  font_byte;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [7:0]  char_code;

    assign font_addr = s_axis_tdata[9:0];
    assign font_byte = s_axis_tdata[17:10];
    assign start_x   = s_axis_tdata[29:18];
    assign start_y   = s_axis_tdata[41:30];
    assign char_code = s_axis_tdata[49:42];

    // Configuration registers
    logic [7:0]  first_code_reg;
    logic [7:0]  last_code_reg;
    logic [3:0]  glyph_width_reg;
    logic [3:0]  glyph_height_reg;
    logic [10:0] table_bytes_reg;
    logic        pixel_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg   <= 8'd32;
            last_code_reg    <= 8'd126;
            glyph_width_reg  <= 4'd5;
            glyph_height_reg <= 4'd8;
            table_bytes_reg  <= 11'd1024;
            pixel_on_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_CODE:   first_code_reg   <= cfg_data[7:0];
                CFG_LAST_CODE:    last_code_reg    <= cfg_data[7:0];
                CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[3:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[3:0];
                CFG_TABLE_BYTES:  table_bytes_reg  <= cfg_data;
                CFG_PIXEL_ON:     pixel_on_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Glyph working registers
    logic [7:0]            code_reg;
    logic                  in_range_reg;
    logic [WW-1:0]         w_reg;
    logic [HW-1:0]         h_reg;
    logic [IDX_W-1:0]      base_reg;
    logic [WW-1:0]         ncols_reg;
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    logic [COORD_BITS-1:0] cursor_reg;
    logic [COORD_BITS-1:0] line_reg;
    logic [11:0]           total_reg;
    logic                  pend_reg;
    logic [CW-1:0]         pidx_reg;
    logic [7:0]            rd_data_reg;
    logic [7:0]            colbuf_reg [MAX_GLYPH_W];
    logic [7:0]            font_mem [FONT_BYTES];

    logic load_fire;
    logic start_fire;
    logic glyph_fire;
    assign load_fire  = cmd.accept && (s_axis_tuser == ACT_LOAD);
    assign start_fire = cmd.accept && (s_axis_tuser == ACT_START);
    assign glyph_fire = cmd.accept && (s_axis_tuser == ACT_GLYPH);

    // Setup terms: range check, effective size, first byte index, saturated width sum
    logic              in_range;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [IDX_W-1:0]  base_calc;
    logic [12:0]       sum_calc;

    assign in_range  = (code_reg >= first_code_reg) && (code_reg <= last_code_reg);
    assign w_eff     = (32'(glyph_width_reg) < MAX_GLYPH_W) ? WW'(glyph_width_reg)
                                                             : WW'(MAX_GLYPH_W);
    assign h_eff     = (32'(glyph_height_reg) < MAX_GLYPH_H) ? HW'(glyph_height_reg)
                                                              : HW'(MAX_GLYPH_H);
    assign base_calc = IDX_W'(code_reg - first_code_reg) * IDX_W'(w_eff);
    assign sum_calc  = {1'b0, total_reg} + 13'(w_eff);

    // Column count: columns whose byte index stays below the table limit
    logic [IDX_W-1:0] limit;
    logic [IDX_W-1:0] remain;
    logic [WW-1:0]    ncols_calc;

    assign limit      = (IDX_W'(table_bytes_reg) < IDX_W'(FONT_BYTES)) ? IDX_W'(table_bytes_reg)
                                                                       : IDX_W'(FONT_BYTES);
    assign remain     = limit - base_reg;
    assign ncols_calc = (base_reg >= limit)          ? '0 :
                        (remain < IDX_W'(w_reg))     ? WW'(remain) : w_reg;

    // Fetch and emit position terms
    logic [FONT_AW-1:0] fetch_addr;
    logic               col_last;
    logic               row_last;
    logic [7:0]         col_shift;
    logic               pix_bit;

    assign fetch_addr = FONT_AW'(base_reg + IDX_W'(col_reg));
    assign col_last   = ((WW'(col_reg) + WW'(1)) == ncols_reg);
    assign row_last   = ((HW'(row_reg) + HW'(1)) == h_reg);
    assign col_shift  = colbuf_reg[col_reg] >> row_reg;
    assign pix_bit    = col_shift[0];

    // Output register
    logic        out_valid_reg;
    logic        out_flag_reg;
    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    logic        out_value_reg;
    logic [3:0]  out_adv_reg;
    logic [11:0] out_sum_reg;
    logic        out_last_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    // Status to the controller
    assign stat.is_glyph   = (s_axis_tuser == ACT_GLYPH);
    assign stat.in_range   = in_range_reg;
    assign stat.no_pixels  = (ncols_calc == '0) || (h_reg == '0);
    assign stat.fetch_last = col_last;
    assign stat.pix_last   = col_last && row_last;
    assign stat.out_free   = out_free;

    // Font store: one write port for loads, one registered read port for fetches
    always_ff @(posedge clk)
    begin
        if (load_fire && (32'(font_addr) < FONT_BYTES))
        begin
            font_mem[FONT_AW'(font_addr)] <= font_byte;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= font_mem[fetch_addr];
        end
    end

    // Column buffer is written from the read data register, with the fetch flag and column index registered alongside
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            colbuf_reg[pidx_reg] <= rd_data_reg;
        end
    end

    // Glyph payload registers
    always_ff @(posedge clk)
    begin
        if (glyph_fire)
        begin
            code_reg <= char_code;
        end
        if (cmd.setup)
        begin
            w_reg    <= w_eff;
            h_reg    <= h_eff;
            base_reg <= base_calc;
        end
        if (cmd.calc)
        begin
            ncols_reg <= ncols_calc;
        end
        if (cmd.fetch)
        begin
            pidx_reg <= col_reg;
        end
    end

    // Cursor, width sum and glyph counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            line_reg     <= '0;
            total_reg    <= '0;
            in_range_reg <= 1'b0;
            pend_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            pend_reg <= cmd.fetch;
            if (start_fire)
            begin
                cursor_reg <= COORD_BITS'($signed(start_x));
                line_reg   <= COORD_BITS'($signed(start_y));
                total_reg  <= '0;
            end
            if (cmd.setup)
            begin
                in_range_reg <= in_range;
                if (in_range)
                begin
                    total_reg <= (sum_calc > 13'd4095) ? 12'hFFF : sum_calc[11:0];
                end
            end
            if (cmd.adv_cursor)
            begin
                cursor_reg <= cursor_reg + COORD_BITS'(w_reg);
            end
            if (cmd.calc)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.fetch || cmd.emit_pixel)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    // Row steps only while pixels go out; fetch ends with row at zero.
                    row_reg <= cmd.fetch ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_pixel || cmd.emit_marker)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_pixel)
        begin
            out_flag_reg  <= 1'b1;
            out_x_reg     <= 12'(cursor_reg + COORD_BITS'(col_reg));
            out_y_reg     <= 12'(line_reg + COORD_BITS'(row_reg));
            out_value_reg <= pix_bit ? pixel_on_reg : ~pixel_on_reg;
            out_adv_reg   <= 4'(w_reg);
            out_sum_reg   <= total_reg;
            out_last_reg  <= col_last && row_last;
        end
        else if (cmd.emit_marker)
        begin
            out_flag_reg  <= 1'b0;
            out_x_reg     <= 12'(cursor_reg);
            out_y_reg     <= 12'(line_reg);
            out_value_reg <= 1'b0;
            out_adv_reg   <= in_range_reg ? 4'(w_reg) : 4'd0;
            out_sum_reg   <= total_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_sum_reg, out_adv_reg, out_value_reg, out_y_reg, out_x_reg};

endmodule

### design/bgpg_checker.sv
// Port-level checker of the glyph pixel generator and its bind to the top level.
module bgpg_checker
    import bgpg_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,   // font_addr, font_byte, start_x, start_y, char_code
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,   // action
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_value, advance, width_sum
    input logic                   m_axis_tuser,   // pixel_valid
    input logic                   m_axis_tlast,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    // A stalled output item stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item withdrawn while stalled");

    // A stalled output item keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // A marker is always the only and final item of its glyph.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("marker without tlast");

    // A marker never carries a pixel value.
    a_marker_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[24])
        else $error("marker with a set pixel value");

    // A pixel write comes from a glyph at least one and at most eight columns wide.
    a_pixel_advance: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[28:25] != 4'd0) && (m_axis_tdata[28:25] <= 4'd8))
        else $error("pixel with an impossible advance");

endmodule

bind bitmap_glyph_pixel_generator bgpg_checker u_bgpg_checker (.*);

### bench/bgpg_pixel_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the pixel stream of the glyph pixel generator.
module bgpg_pixel_checker
    import bgpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // font_addr, font_byte, start_x, start_y, char_code
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // action
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_value, advance, width_sum
    input  logic                   m_axis_tuser,   // pixel_valid
    input  logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     pixels_seen,
    output int                     markers_seen
);

    // One output item of the block, as the checker expects or sees it.
    typedef struct packed {
        logic                  is_pixel;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  value;
        logic                  last;
        logic [3:0]            adv;
        logic [11:0]           wsum;
    } pixel_rec_t;

    // Pixel writes and markers still owed by the block, oldest first.
    pixel_rec_t owed_pixels[$];

    // Shadow of the font store, the registers and the string state.
    logic [7:0]            font_mem [FONT_BYTES];
    logic [7:0]            first_code;
    logic [7:0]            last_code;
    logic [3:0]            glyph_w;
    logic [3:0]            glyph_h;
    logic [10:0]           table_bytes;
    logic                  pixel_on;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] line_y;
    logic [11:0]           width_sum;

    function automatic pixel_rec_t make_pixel(input logic is_pixel,
                                              input logic [COORD_BITS-1:0] x,
                                              input logic [COORD_BITS-1:0] y,
                                              input logic value, input logic last,
                                              input logic [3:0] adv);
        pixel_rec_t rec;
        rec.is_pixel = is_pixel;
        rec.x        = x;
        rec.y        = y;
        rec.value    = value;
        rec.last     = last;
        rec.adv      = adv;
        rec.wsum     = width_sum;
        return rec;
    endfunction

    function automatic string describe(input pixel_rec_t rec);
        return $sformatf("valid=%0b x=%0d y=%0d value=%0b last=%0b advance=%0d width_sum=%0d",
                         rec.is_pixel, $signed(rec.x), $signed(rec.y), rec.value, rec.last,
                         rec.adv, rec.wsum);
    endfunction

    // Work out every output item of one glyph item and queue them in order.
    task automatic draw_glyph(input logic [7:0] code);
        int  w;
        int  h;
        int  lim;
        int  base;
        int  ncols;
        int  sum;
        logic lit;
        if (code < first_code || code > last_code)
        begin
            // Code outside the font: a single marker, the cursor stays put.
            owed_pixels.push_back(make_pixel(1'b0, cursor_x, line_y, 1'b0, 1'b1, 4'd0));
            return;
        end
        w     = (int'(glyph_w) > MAX_GLYPH_W) ? MAX_GLYPH_W : int'(glyph_w);
        h     = (int'(glyph_h) > MAX_GLYPH_H) ? MAX_GLYPH_H : int'(glyph_h);
        lim   = (int'(table_bytes) > FONT_BYTES) ? FONT_BYTES : int'(table_bytes);
        base  = (int'(code) - int'(first_code)) * w;
        ncols = lim - base;
        if (ncols > w)
            ncols = w;
        if (ncols < 0)
            ncols = 0;
        sum       = int'(width_sum) + w;
        width_sum = (sum > 4095) ? 12'd4095 : 12'(sum);
        // Rows outer, columns inner; columns past the byte limit are dropped in every row.
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < ncols; c++)
            begin
                lit = font_mem[base + c][r];
                owed_pixels.push_back(make_pixel(1'b1, COORD_BITS'(int'(cursor_x) + c),
                                                 COORD_BITS'(int'(line_y) + r),
                                                 ~(lit ^ pixel_on),
                                                 (r == h - 1) && (c == ncols - 1), 4'(w)));
            end
        end
        cursor_x = COORD_BITS'(int'(cursor_x) + w);
        // A drawn glyph with no pixel still moves the cursor and reports it in a marker.
        if (ncols == 0 || h == 0)
            owed_pixels.push_back(make_pixel(1'b0, cursor_x, line_y, 1'b0, 1'b1, 4'(w)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_rec_t seen;
        pixel_rec_t owed;
        if (!rst_n)
        begin
            first_code   = 8'd32;
            last_code    = 8'd126;
            glyph_w      = 4'd5;
            glyph_h      = 4'd8;
            table_bytes  = 11'd1024;
            pixel_on     = 1'b1;
            cursor_x     = '0;
            line_y       = '0;
            width_sum    = '0;
            owed_pixels.delete();
            fail_count   <= 0;
            pending      <= 0;
            pixels_seen  <= 0;
            markers_seen <= 0;
        end
        else
        begin
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIRST_CODE:   first_code  = cfg_data[7:0];
                    CFG_LAST_CODE:    last_code   = cfg_data[7:0];
                    CFG_GLYPH_WIDTH:  glyph_w     = cfg_data[3:0];
                    CFG_GLYPH_HEIGHT: glyph_h     = cfg_data[3:0];
                    CFG_TABLE_BYTES:  table_bytes = cfg_data[10:0];
                    CFG_PIXEL_ON:     pixel_on    = cfg_data[0];
                    default: ;
                endcase
            end

            // Compare each accepted output item with the oldest one owed.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.is_pixel = m_axis_tuser;
                seen.x        = m_axis_tdata[11:0];
                seen.y        = m_axis_tdata[23:12];
                seen.value    = m_axis_tdata[24];
                seen.adv      = m_axis_tdata[28:25];
                seen.wsum     = m_axis_tdata[40:29];
                seen.last     = m_axis_tlast;
                if (m_axis_tuser)
                    pixels_seen <= pixels_seen + 1;
                else
                    markers_seen <= markers_seen + 1;
                if (owed_pixels.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected output item: %s", $realtime, describe(seen));
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    owed = owed_pixels.pop_front();
                    if (seen != owed)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch, expected %s", $realtime, describe(owed));
                            $display("%0t:           actual   %s", $realtime, describe(seen));
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end

            // Accepted input items update the shadow state.
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    ACT_LOAD:
                        font_mem[s_axis_tdata[9:0]] = s_axis_tdata[17:10];
                    ACT_START:
                    begin
                        cursor_x  = s_axis_tdata[29:18];
                        line_y    = s_axis_tdata[41:30];
                        width_sum = '0;
                    end
                    ACT_GLYPH:
                        draw_glyph(s_axis_tdata[49:42]);
                    default: ;
                endcase
            end

            pending <= owed_pixels.size();
        end
    end

endmodule

### bench/tb_bitmap_glyph_pixel_generator.sv
`timescale 1ns / 100ps
// Testbench top: stimulus, handshake pacing and verdict for the glyph pixel generator.
module tb_bitmap_glyph_pixel_generator;
    import bgpg_pkg::*;

    localparam int IDLE_PCT     = 18;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 3000;

    // Unused action code; the block drops such items.
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;     // font_addr, font_byte, start_x, start_y, char_code
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;     // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // pixel_x, pixel_y, pixel_value, advance, width_sum
    logic                   m_axis_tuser;           // pixel_valid
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int fail_count;
    int pending;
    int pixels_seen;
    int markers_seen;

    // Pacing controls shared by the sender and the receiver, and run counters.
    logic no_idle     = 1'b0;
    logic pressure_on = 1'b0;
    logic hold_done   = 1'b0;
    int   stall_cycles = 0;
    int   glyphs_sent  = 0;
    int   items_sent   = 0;
    int   settings_used = 1;

    // Current settings and the font bytes loaded so far, so that no glyph reads an empty byte.
    logic [7:0]  cur_first = 8'd32;
    logic [7:0]  cur_last  = 8'd126;
    logic [3:0]  cur_w     = 4'd5;
    logic [10:0] cur_tb    = 11'd1024;
    logic        font_written [FONT_BYTES];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bitmap_glyph_pixel_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bgpg_pixel_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .pixels_seen   (pixels_seen),
        .markers_seen  (markers_seen)
    );

    // Offer one input item, with random idle cycles first, and wait until it is taken.
    task automatic send_item(input logic [1:0] act, input logic [9:0] addr,
                             input logic [7:0] fbyte, input logic [11:0] sx,
                             input logic [11:0] sy, input logic [7:0] code);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, code, sy, sx, fbyte, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic stray_item();
        send_item(ACT_NONE, 10'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
                  8'($urandom));
    endtask

    task automatic load_byte(input logic [9:0] addr, input logic [7:0] fbyte);
        font_written[addr] = 1'b1;
        send_item(ACT_LOAD, addr, fbyte, 12'($urandom), 12'($urandom), 8'($urandom));
    endtask

    task automatic start_string(input logic [11:0] sx, input logic [11:0] sy);
        send_item(ACT_START, 10'($urandom), 8'($urandom), sx, sy, 8'($urandom));
    endtask

    // Draw one character, loading any font byte it reads that was never written.
    task automatic glyph(input logic [7:0] code);
        int w;
        int lim;
        int base;
        w   = int'(cur_w);
        lim = (int'(cur_tb) > FONT_BYTES) ? FONT_BYTES : int'(cur_tb);
        if (code >= cur_first && code <= cur_last)
        begin
            base = (int'(code) - int'(cur_first)) * w;
            for (int c = 0; c < w && base + c < lim; c++)
                if (!font_written[base + c])
                    load_byte(10'(base + c), 8'($urandom));
        end
        glyphs_sent++;
        send_item(ACT_GLYPH, 10'($urandom), 8'($urandom), 12'($urandom), 12'($urandom), code);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering items, wait for every owed output item, then let the block settle.
    task automatic quiesce();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] first, input logic [7:0] final_code,
                                  input logic [3:0] w, input logic [3:0] h,
                                  input logic [10:0] tb, input logic on_value);
        quiesce();
        cfg_write(CFG_FIRST_CODE, CFG_DATA_W'(first));
        cfg_write(CFG_LAST_CODE, CFG_DATA_W'(final_code));
        cfg_write(CFG_GLYPH_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_GLYPH_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_TABLE_BYTES, tb);
        cfg_write(CFG_PIXEL_ON, CFG_DATA_W'(on_value));
        cur_first = first;
        cur_last  = final_code;
        cur_w     = w;
        cur_tb    = tb;
        settings_used++;
    endtask

    // Mostly well-formed strings of glyphs, with stray loads, restarts and dropped items.
    // In-range glyphs keep to the first four codes of the font so that few loads are needed.
    task automatic random_items(input int count);
        int done_count;
        int pick;
        int span;
        done_count = 0;
        while (done_count < count)
        begin
            pick = $urandom_range(99);
            span = int'(cur_last) - int'(cur_first);
            if (span > 3)
                span = 3;
            if (pick < 6)
                start_string(12'($urandom), 12'($urandom));
            else if (pick < 12)
                load_byte(10'($urandom), 8'($urandom));
            else if (pick < 15)
            begin
                stray_item();
                continue;
            end
            else if (pick < 25 || cur_first > cur_last)
                glyph(8'($urandom_range(255)));
            else
                glyph(8'(int'(cur_first) + int'($urandom_range(span))));
            done_count++;
        end
    endtask

    // Receiver pacing: random stalls, once a long hold-off while the sender keeps pushing.
    initial
    begin : receiver_pacing
        forever
        begin
            @(negedge clk);
            if (pressure_on && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : stimulus
        for (int i = 0; i < FONT_BYTES; i++)
            font_written[i] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset settings.
        load_byte(10'd0, 8'hFF);
        load_byte(10'd1023, 8'h00);
        glyph(8'd32);                       // lowest code of the font
        glyph(8'd126);                      // highest code of the font
        glyph(8'd31);                       // just below the range
        glyph(8'd127);                      // just above the range
        glyph(8'd0);
        glyph(8'd255);
        stray_item();
        start_string(12'h800, 12'h7FF);     // most negative column, most positive row
        glyph(8'd65);
        start_string(12'h7FE, 12'hFFF);     // columns and rows wrap around
        glyph(8'd66);
        start_string(12'd0, 12'd0);

        // Full code range, largest glyphs, inverted pixels; the receiver holds off first.
        apply_settings(8'd0, 8'd255, 4'd8, 4'd8, 11'd1024, 1'b0);
        pressure_on <= 1'b1;
        repeat (12) glyph(8'($urandom_range(3)));
        pressure_on <= 1'b0;
        random_items(20);

        // Smallest glyphs over a narrow range, with no idling on either side.
        apply_settings(8'd200, 8'd210, 4'd1, 4'd1, 11'd1024, 1'b1);
        no_idle <= 1'b1;
        random_items(30);
        no_idle <= 1'b0;

        // Random settings.
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                       4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)),
                       11'($urandom_range(1024)), 1'($urandom_range(1)));
        random_items(30);

        // Empty font table: drawn glyphs give only markers that carry the advance.
        apply_settings(8'd10, 8'd20, 4'd3, 4'd2, 11'd0, 1'b1);
        random_items(20);

        // Empty code range.
        apply_settings(8'd255, 8'd0, 4'd4, 4'd3, 11'd1024, 1'b0);
        random_items(15);

        // Partial table: glyphs near the byte limit lose their right-hand columns.
        apply_settings(8'd32, 8'd255, 4'd7, 4'd5, 11'd500, 1'b0);
        glyph(8'd102);                      // last glyph that fits whole
        glyph(8'd103);                      // only three columns below the limit
        glyph(8'd104);                      // every column past the limit
        random_items(30);

        // String of fast glyphs that give only markers, move the cursor and grow the width sum.
        apply_settings(8'd0, 8'd255, 4'd8, 4'd1, 11'd0, 1'b1);
        start_string(12'($urandom), 12'($urandom));
        repeat (30) glyph(8'($urandom));

        quiesce();
        $display("Run covered %0d input items (%0d glyphs) under %0d register settings.",
                 items_sent, glyphs_sent, settings_used);
        $display("Checked %0d pixel writes and %0d markers, range edges, clipped tables, wrap.",
                 pixels_seen, markers_seen);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### bitmap_glyph_pixel_generator.f
design/bgpg_pkg.sv
design/bgpg_ctrl.sv
design/bgpg_datapath.sv
design/bitmap_glyph_pixel_generator.sv
design/bgpg_checker.sv
bench/bgpg_pixel_checker.sv
bench/tb_bitmap_glyph_pixel_generator.sv
